@@ hw/rtl/sdti_pkg.sv @@
// ----------------------------------------------------------------------------
// sdti_pkg
// Shared types and constants for the sorted delta table insert unit.
// ----------------------------------------------------------------------------
package sdti_pkg;

    localparam int DEF_VECTOR_SIZE = 1024;
    localparam int DEF_DATA_WIDTH  = 64;

    localparam int ROW_W   = 40;
    localparam int VALUE_W = 64;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;

    typedef struct packed {
        logic [ROW_W-1:0]          row_id;
        logic [ROW_W-1:0]          vector_base;
        logic signed [VALUE_W-1:0] new_value;
        logic                      is_null;
        logic                      end_of_batch;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]         slot;
        logic                      was_new;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] minimum_seen;
        logic signed [VALUE_W-1:0] maximum_seen;
        logic                      out_of_range;
        logic                      batch_done;
    } t_out_item;

    typedef struct packed {
        logic                      en;
        logic signed [VALUE_W-1:0] value;
    } t_stat_upd;

endpackage

@@ hw/rtl/sdti_stats.sv @@
// ----------------------------------------------------------------------------
// sdti_stats
// Running minimum and maximum of the non-null values written to the table.
// ----------------------------------------------------------------------------
module sdti_stats #(
    parameter int DATA_WIDTH = sdti_pkg::DEF_DATA_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sdti_pkg::t_stat_upd                  i_upd,
    output logic signed [sdti_pkg::VALUE_W-1:0]  o_min,
    output logic signed [sdti_pkg::VALUE_W-1:0]  o_max
);

    localparam int VALUE_W = sdti_pkg::VALUE_W;

    logic signed [DATA_WIDTH-1:0] r_min;
    logic signed [DATA_WIDTH-1:0] r_max;
    logic signed [DATA_WIDTH-1:0] upd_val;

    assign upd_val = i_upd.value[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
            r_max <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else if (i_upd.en) begin
            if (upd_val < r_min) begin
                r_min <= upd_val;
            end
            if (upd_val > r_max) begin
                r_max <= upd_val;
            end
        end
    end

    assign o_min = VALUE_W'(r_min);
    assign o_max = VALUE_W'(r_max);

endmodule

@@ hw/rtl/sorted_delta_table_insert_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_delta_table_insert_unit
// Steps: accept, a binary search over the stored offsets (each step reads
// an entry, then compares it), a closing search step, a shift that moves
// each entry above the insert position up by one (skipped on a hit, a full
// table or an out-of-range row), and a commit that waits for a free output
// slot. One item at a time: a new item is accepted only in idle, after the
// last one has committed. Reset clears the count and statistics at once;
// table contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_delta_table_insert_unit #(
    parameter int VECTOR_SIZE = sdti_pkg::DEF_VECTOR_SIZE,
    parameter int DATA_WIDTH  = sdti_pkg::DEF_DATA_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sdti_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sdti_pkg::t_out_item o_out_item
);

    localparam int OFF_W   = $clog2(VECTOR_SIZE);
    localparam int CNT_W   = $clog2(VECTOR_SIZE + 1);
    localparam int ENT_W   = OFF_W + DATA_WIDTH + 1;
    localparam int ROW_W   = sdti_pkg::ROW_W;
    localparam int SLOT_W  = sdti_pkg::SLOT_W;
    localparam int COUNT_W = sdti_pkg::COUNT_W;
    localparam int VALUE_W = sdti_pkg::VALUE_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_lo;
    logic [CNT_W-1:0]             r_hi;
    logic [CNT_W-1:0]             r_mid;
    logic [CNT_W-1:0]             r_j;
    logic                         r_pend;
    logic [OFF_W-1:0]             r_pend_addr;
    logic                         r_hit;
    logic                         r_new;
    logic                         r_oor;
    logic [OFF_W-1:0]             r_off;
    logic signed [DATA_WIDTH-1:0] r_val;
    logic                         r_nul;
    logic                         r_eob;
    logic                         r_out_valid;
    logic [SLOT_W-1:0]            r_out_slot;
    logic                         r_out_new;
    logic                         r_out_oor;
    logic                         r_out_eob;

    logic [ENT_W-1:0]             r_mem [VECTOR_SIZE];
    logic [ENT_W-1:0]             r_rd_data;
    logic [OFF_W-1:0]             rd_addr;
    logic                         wr_en;
    logic [OFF_W-1:0]             wr_addr;
    logic [ENT_W-1:0]             wr_data;

    logic [ROW_W-1:0]             diff;
    logic                         in_oor;
    logic                         in_fire;
    logic                         out_free;
    logic                         commit;
    logic [CNT_W-1:0]             mid;
    logic [CNT_W-1:0]             j_dec;
    logic [OFF_W-1:0]             rd_off;
    sdti_pkg::t_stat_upd          stat_upd;
    logic signed [VALUE_W-1:0]    stat_min;
    logic signed [VALUE_W-1:0]    stat_max;

    assign diff     = i_in_item.row_id - i_in_item.vector_base;
    assign in_oor   = (i_in_item.row_id < i_in_item.vector_base)
                   || (diff >= ROW_W'(VECTOR_SIZE));
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign commit   = (r_state == S_FINISH) && out_free;
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign j_dec    = r_j - CNT_W'(1);
    assign rd_off   = r_rd_data[ENT_W-1 -: OFF_W];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = r_rd_data;
        unique case (r_state)
            S_SEARCH: begin
                rd_addr = mid[OFF_W-1:0];
            end
            S_SHIFT: begin
                rd_addr = j_dec[OFF_W-1:0];
                wr_en   = r_pend;
            end
            S_FINISH: begin
                wr_en   = commit && !r_oor;
                wr_addr = r_lo[OFF_W-1:0];
                wr_data = {r_off, r_val, r_nul};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = in_oor ? S_FINISH : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_CMP;
                end else if (r_hit || r_count == CNT_W'(VECTOR_SIZE)) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_CMP: begin
                n_state = S_SEARCH;
            end
            S_SHIFT: begin
                if (r_j == r_lo) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
                if (r_new && !r_oor) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_SHIFT) begin
                r_pend <= (r_j != r_lo);
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_off <= diff[OFF_W-1:0];
                    r_val <= i_in_item.new_value[DATA_WIDTH-1:0];
                    r_nul <= i_in_item.is_null;
                    r_eob <= i_in_item.end_of_batch;
                    r_oor <= in_oor;
                    r_new <= 1'b0;
                    r_hit <= 1'b0;
                    r_lo  <= '0;
                    r_hi  <= r_count;
                end
            end
            S_SEARCH: begin
                r_mid <= mid;
                r_j   <= r_count;
                if (!(r_lo < r_hi) && !r_hit) begin
                    if (r_count == CNT_W'(VECTOR_SIZE)) begin
                        r_oor <= 1'b1;
                    end else begin
                        r_new <= 1'b1;
                    end
                end
            end
            S_CMP: begin
                if (rd_off < r_off) begin
                    r_lo <= r_mid + CNT_W'(1);
                end else begin
                    r_hi <= r_mid;
                end
                if (rd_off == r_off) begin
                    r_hit <= 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_j != r_lo) begin
                    r_pend_addr <= r_j[OFF_W-1:0];
                    r_j         <= j_dec;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    r_out_slot <= r_oor ? '0 : SLOT_W'(r_lo);
                    r_out_new  <= r_new && !r_oor;
                    r_out_oor  <= r_oor;
                    r_out_eob  <= r_eob;
                end
            end
            default: begin
            end
        endcase
    end

    assign stat_upd.en    = commit && !r_oor && !r_nul;
    assign stat_upd.value = VALUE_W'(r_val);

    sdti_stats #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (stat_upd),
        .o_min   (stat_min),
        .o_max   (stat_max)
    );

    assign o_out_valid              = r_out_valid;
    assign o_out_item.slot          = r_out_slot;
    assign o_out_item.was_new       = r_out_new;
    assign o_out_item.entry_count   = COUNT_W'(r_count);
    assign o_out_item.minimum_seen  = stat_min;
    assign o_out_item.maximum_seen  = stat_max;
    assign o_out_item.out_of_range  = r_out_oor;
    assign o_out_item.batch_done    = r_out_eob;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(VECTOR_SIZE))
        else $error("entry count exceeds table size");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_CMP) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("search window out of order");

    a_shift_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_j >= r_lo))
        else $error("shift ran below insert position");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_new && !r_oor) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the table");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_new && r_out_oor))
        else $error("item both inserted and rejected");

endmodule

@@ verif/sorted_delta_table_insert_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_delta_table_insert_unit_tb
// Self-checking bench for the sorted delta table insert unit. Updates are
// sent over the input handshake and every accepted item is run through a
// local model of the sorted table. The model tracks offsets, values, null
// marks, count and running min/max. Each result is compared field by field
// in order. Directed corner cases come first, then random update streams
// with bursty stalls on both sides, a drain pause and a stall-free tail.
// ----------------------------------------------------------------------------
module sorted_delta_table_insert_unit_tb;
    import sdti_pkg::*;

    localparam int          VSIZE        = DEF_VECTOR_SIZE;
    localparam int          LIMIT_CYCLES = 3_000_000;
    localparam int          TAIL_CYCLES  = 1_100;
    localparam logic [39:0] ROW_MAX      = '1;
    localparam logic [63:0] VAL_MAX      = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] VAL_MIN      = 64'h8000_0000_0000_0000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b1;
    t_out_item o_out_item;

    logic [SLOT_W-1:0]         tbl_off  [0:VSIZE-1];
    logic signed [VALUE_W-1:0] tbl_val  [0:VSIZE-1];
    logic                      tbl_null [0:VSIZE-1];
    int                        tbl_count = 0;
    logic signed [VALUE_W-1:0] run_min = VAL_MAX;
    logic signed [VALUE_W-1:0] run_max = VAL_MIN;

    t_out_item expected_results [$];
    t_out_item want;
    int        errors = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b0;

    sorted_delta_table_insert_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results pending", $realtime,
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_out_item predict_table_update(input t_in_item it);
        t_out_item                 r;
        logic [ROW_W-1:0]          diff;
        logic [SLOT_W-1:0]         off;
        logic signed [VALUE_W-1:0] v;
        int                        lo;
        int                        hi;
        int                        mid;
        int                        j;
        r = '0;
        r.batch_done = it.end_of_batch;
        v = $signed(it.new_value);
        diff = it.row_id - it.vector_base;
        if (it.row_id < it.vector_base || diff >= VSIZE) begin
            r.out_of_range = 1'b1;
        end else begin
            off = diff[SLOT_W-1:0];
            lo = 0;
            hi = tbl_count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (tbl_off[mid] < off) lo = mid + 1;
                else hi = mid;
            end
            if (lo < tbl_count && tbl_off[lo] == off) begin
                r.slot = SLOT_W'(lo);
            end else if (tbl_count >= VSIZE) begin
                r.out_of_range = 1'b1;
            end else begin
                for (j = tbl_count; j > lo; j--) begin
                    tbl_off[j]  = tbl_off[j-1];
                    tbl_val[j]  = tbl_val[j-1];
                    tbl_null[j] = tbl_null[j-1];
                end
                tbl_off[lo] = off;
                tbl_count++;
                r.slot    = SLOT_W'(lo);
                r.was_new = 1'b1;
            end
            if (!r.out_of_range) begin
                tbl_val[r.slot]  = v;
                tbl_null[r.slot] = it.is_null;
                if (!it.is_null) begin
                    if (v < run_min) run_min = v;
                    if (v > run_max) run_max = v;
                end
            end
        end
        r.entry_count  = COUNT_W'(tbl_count);
        r.minimum_seen = run_min;
        r.maximum_seen = run_max;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name,
                     exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item: expected none, actual %p",
                             $realtime, o_out_item);
                end else begin
                    want = expected_results.pop_front();
                    check_field("slot", want.slot, o_out_item.slot);
                    check_field("was_new", want.was_new, o_out_item.was_new);
                    check_field("entry_count", want.entry_count, o_out_item.entry_count);
                    check_field("minimum_seen", want.minimum_seen,
                                o_out_item.minimum_seen);
                    check_field("maximum_seen", want.maximum_seen,
                                o_out_item.maximum_seen);
                    check_field("out_of_range", want.out_of_range,
                                o_out_item.out_of_range);
                    check_field("batch_done", want.batch_done, o_out_item.batch_done);
                end
            end
            if (i_in_valid && o_in_ready)
                expected_results.push_back(predict_table_update(i_in_item));
        end
    end

    function automatic t_in_item make_update(input logic [39:0] row,
                                             input logic [39:0] base,
                                             input logic [63:0] value,
                                             input logic nul, input logic eob);
        t_in_item it;
        it.row_id       = row;
        it.vector_base  = base;
        it.new_value    = value;
        it.is_null      = nul;
        it.end_of_batch = eob;
        return it;
    endfunction

    function automatic t_in_item make_random_update();
        t_in_item    it;
        int          pick;
        logic [39:0] base;
        logic [39:0] row;
        logic [63:0] value;
        pick = $urandom_range(0, 99);
        base = {8'($urandom_range(0, 255)), 32'($urandom)};
        if (pick < 25 && tbl_count > 0) begin
            row = base + tbl_off[$urandom_range(0, tbl_count - 1)];
        end else if (pick < 60) begin
            row = base + $urandom_range(0, VSIZE - 1);
        end else if (pick < 75) begin
            if (base == 0) base = 1;
            row = base - 40'($urandom_range(1, 5000)) % base - 1;
            if (row >= base) row = base - 1;
        end else if (pick < 90) begin
            row = base + VSIZE + $urandom_range(0, 100000);
        end else begin
            row = {8'($urandom_range(0, 255)), 32'($urandom)};
        end
        case ($urandom_range(0, 11))
            0: value = VAL_MAX;
            1: value = VAL_MIN;
            2: value = '0;
            3: value = '1;
            default: value = {32'($urandom), 32'($urandom)};
        endcase
        it = make_update(row, base, value, $urandom_range(0, 3) == 0,
                         $urandom_range(0, 7) == 0);
        return it;
    endfunction

    task automatic send_update(input t_in_item it);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        int k;
        idle_on = 1'b1;
        send_update(make_update(40'd5, 40'd6, 64'd7, 1'b0, 1'b0));
        send_update(make_update(40'd1024, 40'd0, 64'd1, 1'b0, 1'b0));
        send_update(make_update(40'd500, 40'd0, 64'd0, 1'b0, 1'b0));
        send_update(make_update(40'd0, 40'd0, VAL_MAX, 1'b0, 1'b0));
        send_update(make_update(ROW_MAX, ROW_MAX - 40'd1023, VAL_MIN, 1'b0, 1'b1));
        send_update(make_update(40'd1200, 40'd1000, 64'd123, 1'b1, 1'b0));
        send_update(make_update(40'd500, 40'd0, '1, 1'b0, 1'b0));
        send_update(make_update(ROW_MAX, ROW_MAX, 64'd55, 1'b1, 1'b0));
        send_update(make_update(40'd0, 40'd0, 64'd9, 1'b0, 1'b1));
        send_update(make_update(40'd0, ROW_MAX, 64'd3, 1'b0, 1'b0));
        send_update(make_update(40'd3000, 40'd0, 64'd4, 1'b1, 1'b1));
        for (k = 10; k >= 4; k--)
            send_update(make_update(40'h80_0000_0000 + k, 40'h80_0000_0000,
                                    64'(k) - 64'd6, 1'b0, 1'b0));
        send_update(make_update(40'd1022, 40'd0, 64'h5555_aaaa_5555_aaaa, 1'b0, 1'b0));
        send_update(make_update(40'd2047, 40'd1024, 64'haaaa_5555_aaaa_5555, 1'b1, 1'b1));
        wait_drained();
    endtask

    task automatic test_random_updates(input int count);
        idle_on = 1'b1;
        repeat (count) send_update(make_random_update());
    endtask

    task automatic test_drain_pause(input int count);
        idle_on = 1'b1;
        repeat (count) send_update(make_random_update());
        wait_drained();
        repeat ($urandom_range(1, 4)) @(posedge i_clk);
    endtask

    task automatic test_steady_stream(input int count);
        idle_on = 1'b0;
        repeat (count) send_update(make_random_update());
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        test_random_updates(220);
        test_drain_pause(40);
        test_random_updates(220);
        test_steady_stream(100);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/sdti_pkg.sv
hw/rtl/sdti_stats.sv
hw/rtl/sorted_delta_table_insert_unit.sv
verif/sorted_delta_table_insert_unit_tb.sv
